[hdl/spdr_pkg.sv]
// Shared constants for the status packet display renderer: framing, colors, layout.
`timescale 1ns / 1ps

package spdr_pkg;

  localparam int unsigned ColorW    = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned XW        = 8;
  localparam int unsigned YW        = 7;
  localparam int unsigned BarsW     = 3;
  localparam int unsigned CoordW    = 11;
  localparam int unsigned MagicLen  = 4;
  localparam int unsigned LinkPos   = 4;
  localparam int unsigned RssiPos   = 5;
  localparam int unsigned NumBars   = 4;

  localparam logic [ByteW-1:0] MagicA = 8'h41;  // 'A'
  localparam logic [ByteW-1:0] MagicC = 8'h43;  // 'C'
  localparam logic [ByteW-1:0] MagicW = 8'h57;  // 'W'
  localparam logic [ByteW-1:0] Magic1 = 8'h31;  // '1'

  localparam logic [ColorW-1:0] ColBackground = 32'hff121a2e;
  localparam logic [ColorW-1:0] ColPanel      = 32'hff223052;
  localparam logic [ColorW-1:0] ColOn         = 32'hff55d68c;
  localparam logic [ColorW-1:0] ColOffLink    = 32'hffef6471;
  localparam logic [ColorW-1:0] ColInactive   = 32'hff4b5874;

  localparam logic signed [ByteW-1:0] RssiBars4 = -8'sd55;
  localparam logic signed [ByteW-1:0] RssiBars3 = -8'sd67;
  localparam logic signed [ByteW-1:0] RssiBars2 = -8'sd75;

  localparam logic [BarsW-1:0] Bars0 = 3'd0;
  localparam logic [BarsW-1:0] Bars1 = 3'd1;
  localparam logic [BarsW-1:0] Bars2 = 3'd2;
  localparam logic [BarsW-1:0] Bars3 = 3'd3;
  localparam logic [BarsW-1:0] Bars4 = 3'd4;

  // Panel box: x 10..149, y 10..69
  localparam logic [CoordW-1:0] PanelX0 = 11'd10;
  localparam logic [CoordW-1:0] PanelX1 = 11'd150;
  localparam logic [CoordW-1:0] PanelY0 = 11'd10;
  localparam logic [CoordW-1:0] PanelY1 = 11'd70;

  // Indicator box: x 20..37, y 22..57
  localparam logic [CoordW-1:0] IndX0 = 11'd20;
  localparam logic [CoordW-1:0] IndX1 = 11'd38;
  localparam logic [CoordW-1:0] IndY0 = 11'd22;
  localparam logic [CoordW-1:0] IndY1 = 11'd58;

  // Bars: x 58+20b..69+20b, rows 50-10b..57
  localparam int unsigned BarX0    = 58;
  localparam int unsigned BarPitch = 20;
  localparam int unsigned BarWidth = 12;
  localparam int unsigned BarBase  = 58;
  localparam int unsigned BarH0    = 8;
  localparam int unsigned BarHStep = 10;

  typedef enum logic {
    CmdByte  = 1'b0,
    CmdPixel = 1'b1
  } cmd_e;

  function automatic logic [ByteW-1:0] magic_byte(input logic [1:0] idx);
    logic [ByteW-1:0] b;
    case (idx)
      2'd0:    b = MagicA;
      2'd1:    b = MagicC;
      2'd2:    b = MagicW;
      default: b = Magic1;
    endcase
    return b;
  endfunction

  function automatic logic [BarsW-1:0] bars_for(input logic link,
                                                input logic [ByteW-1:0] strength);
    logic [BarsW-1:0] n;
    if (!link) begin
      n = Bars0;
    end else if ($signed(strength) >= RssiBars4) begin
      n = Bars4;
    end else if ($signed(strength) >= RssiBars3) begin
      n = Bars3;
    end else if ($signed(strength) >= RssiBars2) begin
      n = Bars2;
    end else begin
      n = Bars1;
    end
    return n;
  endfunction

endpackage

[hdl/status_packet_display_renderer.sv]
// Top level: serial status framer and layered status image pixel reader.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------------
//   input    | in_valid_i / in_stall_o    | command_i, byte_value_i, pixel_x_i, pixel_y_i
//   output   | out_valid_o / out_stall_i  | pixel_color_o, packet_done_o, link_up_o,
//            |                            | bar_count_o
//
// One item per cycle sustained while the output does not stall; each item passes through
// the input register, then the result register, with the single compare-and-select stage between.
// Reset clears the framer, pending and shown status and both valid flags; no item is
// lost or repeated across reset release. A stall on the output holds the result and
// backs up into the input register; the input side stalls only when both are full.
`timescale 1ns / 1ps

module status_packet_display_renderer #(
  parameter int unsigned SCREEN_WIDTH  = 160,
  parameter int unsigned SCREEN_HEIGHT = 80,
  parameter int unsigned FRAME_LENGTH  = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [spdr_pkg::ByteW-1:0]    byte_value_i,
  input  logic [spdr_pkg::XW-1:0]       pixel_x_i,
  input  logic [spdr_pkg::YW-1:0]       pixel_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [spdr_pkg::ColorW-1:0]   pixel_color_o,
  output logic                          packet_done_o,
  output logic                          link_up_o,
  output logic [spdr_pkg::BarsW-1:0]    bar_count_o
);
  import spdr_pkg::*;

  localparam int unsigned PosW = $clog2(FRAME_LENGTH);
  localparam logic [PosW-1:0] PosLast  = PosW'(FRAME_LENGTH - 1);
  localparam logic [PosW-1:0] PosMagic = PosW'(MagicLen);
  localparam logic [PosW-1:0] PosLink  = PosW'(LinkPos);
  localparam logic [PosW-1:0] PosRssi  = PosW'(RssiPos);
  localparam logic [CoordW-1:0] ScreenW = CoordW'(SCREEN_WIDTH);
  localparam logic [CoordW-1:0] ScreenH = CoordW'(SCREEN_HEIGHT);

  // Input register
  logic              s1_valid_q;
  cmd_e              s1_cmd_q;
  logic [ByteW-1:0]  s1_byte_q;
  logic [XW-1:0]     s1_x_q;
  logic [YW-1:0]     s1_y_q;

  // Framer and status state
  logic [PosW-1:0]   pos_q, pos_d;
  logic              pend_link_q, pend_link_d;
  logic [ByteW-1:0]  pend_rssi_q, pend_rssi_d;
  logic              shown_link_q, shown_link_d;
  logic [BarsW-1:0]  shown_bars_q, shown_bars_d;

  // Result register
  logic              out_valid_q;
  logic [ColorW-1:0] color_q, color_d;
  logic              done_q, done_d;

  logic s1_advance;
  logic in_accept;

  assign s1_advance = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Framer and status update
  always_comb begin
    logic             link_now;
    logic [ByteW-1:0] rssi_now;
    pos_d        = pos_q;
    pend_link_d  = pend_link_q;
    pend_rssi_d  = pend_rssi_q;
    shown_link_d = shown_link_q;
    shown_bars_d = shown_bars_q;
    done_d       = 1'b0;
    link_now     = pend_link_q;
    rssi_now     = pend_rssi_q;
    if (s1_cmd_q == CmdByte) begin
      if (pos_q < PosMagic) begin
        if (s1_byte_q == magic_byte(pos_q[1:0])) begin
          pos_d = pos_q + PosW'(1);
        end else if (s1_byte_q == MagicA) begin
          pos_d = PosW'(1);
        end else begin
          pos_d = '0;
        end
      end else begin
        if (pos_q == PosLink) begin
          link_now = (s1_byte_q != '0);
        end
        if (pos_q == PosRssi) begin
          rssi_now = s1_byte_q;
        end
        pend_link_d = link_now;
        pend_rssi_d = rssi_now;
        if (pos_q == PosLast) begin
          // A short frame ends on the RSSI byte, so use the fresh values.
          shown_link_d = link_now;
          shown_bars_d = bars_for(link_now, rssi_now);
          pos_d        = '0;
          done_d       = 1'b1;
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  // Pixel layers, later ones drawn over earlier ones
  always_comb begin
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    x       = CoordW'(s1_x_q);
    y       = CoordW'(s1_y_q);
    color_d = '0;
    if (s1_cmd_q == CmdPixel && x < ScreenW && y < ScreenH) begin
      color_d = ColBackground;
      if (x >= PanelX0 && x < PanelX1 && y >= PanelY0 && y < PanelY1) begin
        color_d = ColPanel;
      end
      if (x >= IndX0 && x < IndX1 && y >= IndY0 && y < IndY1) begin
        color_d = shown_link_q ? ColOn : ColOffLink;
      end
      for (int b = 0; b < NumBars; b++) begin
        if (x >= CoordW'(BarX0 + b * BarPitch)
            && x < CoordW'(BarX0 + b * BarPitch + BarWidth)
            && y >= CoordW'(BarBase - BarH0 - b * BarHStep)
            && y < CoordW'(BarBase)) begin
          color_d = (BarsW'(b) < shown_bars_q) ? ColOn : ColInactive;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      pos_q        <= '0;
      pend_link_q  <= 1'b0;
      pend_rssi_q  <= '0;
      shown_link_q <= 1'b0;
      shown_bars_q <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_q  <= 1'b1;
        pos_q        <= pos_d;
        pend_link_q  <= pend_link_d;
        pend_rssi_q  <= pend_rssi_d;
        shown_link_q <= shown_link_d;
        shown_bars_q <= shown_bars_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q  <= cmd_e'(command_i);
      s1_byte_q <= byte_value_i;
      s1_x_q    <= pixel_x_i;
      s1_y_q    <= pixel_y_i;
    end
    if (s1_advance) begin
      color_q <= color_d;
      done_q  <= done_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_color_o = color_q;
  assign packet_done_o = done_q;
  // Shown status is updated together with the result register, so it matches this item.
  assign link_up_o     = shown_link_q;
  assign bar_count_o   = shown_bars_q;

endmodule
